// ----- hw/rtl/ffpea_pkg.sv -----
// Shared types and constants for the first-fit page extent allocator.
`default_nettype none
package ffpea_pkg;
   localparam int MAX_EXTENTS     = 64;
   localparam int PAGE_INDEX_BITS = 36;
   localparam int COUNT_BITS      = 16;
   localparam int IDX_BITS        = $clog2(MAX_EXTENTS);
   localparam int TOTAL_BITS      = $clog2(MAX_EXTENTS + 1);

   typedef logic [PAGE_INDEX_BITS-1:0] page_type;
   typedef logic [COUNT_BITS-1:0]      count_type;
   typedef logic [IDX_BITS-1:0]        idx_type;
   typedef logic [TOTAL_BITS-1:0]      total_type;

   localparam page_type PG_MASK = {PAGE_INDEX_BITS{1'b1}};
   localparam total_type TOTAL_MAX = TOTAL_BITS'(MAX_EXTENTS);

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOSPACE = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_ZERO    = 2'd3
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_DROP,
      ST_SHIFT,
      ST_INSERT,
      ST_DONE
   } state_type;

   typedef struct packed {
      page_type base;
      page_type size;
   } ext_type;
endpackage
`default_nettype wire

// ----- hw/rtl/ffpea_req_if.sv -----
// Request channel: valid/ready plus the request beat.
`default_nettype none
interface ffpea_req_if;
   logic                 valid;
   logic                 ready;
   logic                 op;
   ffpea_pkg::count_type page_count;
   ffpea_pkg::page_type  start_page;

   modport source (output valid, output op, output page_count, output start_page,
                   input ready);
   modport sink   (input valid, input op, input page_count, input start_page,
                   output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ffpea_rsp_if.sv -----
// Response channel: valid/ready plus the response beat.
`default_nettype none
interface ffpea_rsp_if;
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   ffpea_pkg::page_type  alloc_start;
   ffpea_pkg::total_type extents_in_use;

   modport source (output valid, output status, output alloc_start,
                   output extents_in_use, input ready);
   modport sink   (input valid, input status, input alloc_start,
                   input extents_in_use, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ffpea_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none
module ffpea_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/first_fit_page_extent_allocator.sv -----
// Top level: first-fit page extent allocator with coalescing on free.
// A zero count or a free clipped to nothing goes straight to the response; other requests
//   scan the table and may then remove an entry or insert one.
// Throughput: one request at a time; the next one is taken once the response is in the
//   output register; a stalled response holds the block in DONE.
// Reset: synchronous, clears the extent count and control; table contents stay undefined.
`default_nettype none
module first_fit_page_extent_allocator (
   input wire logic   clock,
   input wire logic   reset,
   ffpea_req_if.sink   req_chan,
   ffpea_rsp_if.source rsp_chan
);
   // state and request registers
   ffpea_pkg::state_type  state_ff, state_in;
   logic                  op_ff, op_in;
   ffpea_pkg::count_type  cnt_ff, cnt_in;
   ffpea_pkg::page_type   start_ff, start_in;
   ffpea_pkg::total_type  total_ff, total_in;

   // table walk
   ffpea_pkg::total_type  rd_idx_ff, rd_idx_in;   // next entry to read
   ffpea_pkg::total_type  chk_ff, chk_in;         // entry whose data is in flight / write target
   logic                  pend_ff, pend_in;       // RAM read data valid this cycle
   ffpea_pkg::ext_type    prev_ff, prev_in;       // entry below the hit
   ffpea_pkg::ext_type    cur_ff, cur_in;         // hit entry
   ffpea_pkg::total_type  pos_ff, pos_in;
   logic                  found_ff, found_in;

   // result
   ffpea_pkg::status_type status_ff, status_in;
   ffpea_pkg::page_type   where_ff, where_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ffpea_pkg::status_type rsp_status_ff, rsp_status_in;
   ffpea_pkg::page_type   rsp_start_ff, rsp_start_in;
   ffpea_pkg::total_type  rsp_total_ff, rsp_total_in;

   // RAM port
   logic                  we;
   ffpea_pkg::idx_type    waddr;
   ffpea_pkg::ext_type    wdata;
   ffpea_pkg::idx_type    raddr;
   ffpea_pkg::ext_type    rdata;

   // combinational helpers
   ffpea_pkg::page_type   cnt_ext;
   logic [ffpea_pkg::PAGE_INDEX_BITS:0] req_end;
   ffpea_pkg::count_type  clip_cnt;
   logic [ffpea_pkg::PAGE_INDEX_BITS:0] lo_end;
   logic [ffpea_pkg::PAGE_INDEX_BITS:0] run_end;
   logic                  join_lo, join_hi, hit;
   ffpea_pkg::total_type  pos_m1, rd_m1;

   ffpea_ram #(
      .WIDTH ($bits(ffpea_pkg::ext_type)),
      .DEPTH (ffpea_pkg::MAX_EXTENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   assign req_chan.ready        = (state_ff == ffpea_pkg::ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.alloc_start  = rsp_start_ff;
   assign rsp_chan.extents_in_use = rsp_total_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cnt_in        = cnt_ff;
      start_in      = start_ff;
      total_in      = total_ff;
      rd_idx_in     = rd_idx_ff;
      chk_in        = chk_ff;
      pend_in       = pend_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      where_in      = where_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_total_in  = rsp_total_ff;
      we            = 1'b0;
      waddr         = '0;
      wdata         = '0;
      raddr         = '0;

      cnt_ext  = ffpea_pkg::PAGE_INDEX_BITS'(cnt_ff);
      // free runs are clipped below the all-ones page
      req_end  = {1'b0, req_chan.start_page}
               + (ffpea_pkg::PAGE_INDEX_BITS + 1)'(req_chan.page_count);
      clip_cnt = req_chan.page_count;
      if (req_end > {1'b0, ffpea_pkg::PG_MASK}) begin
         clip_cnt = ffpea_pkg::COUNT_BITS'(ffpea_pkg::PG_MASK - req_chan.start_page);
      end

      lo_end  = {1'b0, prev_ff.base} + {1'b0, prev_ff.size};
      run_end = {1'b0, start_ff} + {1'b0, cnt_ext};
      join_lo = (pos_ff != '0) && (lo_end == {1'b0, start_ff});
      join_hi = found_ff && (run_end == {1'b0, cur_ff.base});
      pos_m1  = pos_ff - ffpea_pkg::TOTAL_BITS'(1);
      rd_m1   = rd_idx_ff - ffpea_pkg::TOTAL_BITS'(1);

      if (op_ff == ffpea_pkg::OP_FREE) begin
         hit = pend_ff && (rdata.base >= start_ff);
      end else begin
         hit = pend_ff && (rdata.size >= cnt_ext);
      end

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ffpea_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               op_in     = req_chan.op;
               start_in  = req_chan.start_page;
               cnt_in    = req_chan.page_count;
               rd_idx_in = '0;
               pend_in   = 1'b0;
               found_in  = 1'b0;
               where_in  = '0;
               status_in = ffpea_pkg::STATUS_OK;
               if (req_chan.page_count == '0) begin
                  status_in = ffpea_pkg::STATUS_ZERO;
                  state_in  = ffpea_pkg::ST_DONE;
               end else if (req_chan.op == ffpea_pkg::OP_FREE) begin
                  cnt_in = clip_cnt;
                  if (clip_cnt == '0) begin
                     state_in = ffpea_pkg::ST_DONE;
                  end else begin
                     state_in = ffpea_pkg::ST_SCAN;
                  end
               end else begin
                  state_in = ffpea_pkg::ST_SCAN;
               end
            end
         end

         // one read issued per cycle, data checked the cycle after
         ffpea_pkg::ST_SCAN: begin
            if (hit) begin
               pos_in   = chk_ff;
               cur_in   = rdata;
               found_in = 1'b1;
               pend_in  = 1'b0;
               state_in = ffpea_pkg::ST_APPLY;
            end else begin
               if (pend_ff) begin
                  prev_in = rdata;
               end
               if (rd_idx_ff < total_ff) begin
                  raddr     = rd_idx_ff[ffpea_pkg::IDX_BITS-1:0];
                  pend_in   = 1'b1;
                  chk_in    = rd_idx_ff;
                  rd_idx_in = rd_idx_ff + ffpea_pkg::TOTAL_BITS'(1);
               end else begin
                  pend_in  = 1'b0;
                  pos_in   = total_ff;
                  found_in = 1'b0;
                  state_in = ffpea_pkg::ST_APPLY;
               end
            end
         end

         ffpea_pkg::ST_APPLY: begin
            pend_in = 1'b0;
            if (op_ff == ffpea_pkg::OP_ALLOC) begin
               if (!found_ff) begin
                  status_in = ffpea_pkg::STATUS_NOSPACE;
                  state_in  = ffpea_pkg::ST_DONE;
               end else begin
                  where_in = cur_ff.base;
                  if (cur_ff.size == cnt_ext) begin
                     rd_idx_in = pos_ff + ffpea_pkg::TOTAL_BITS'(1);
                     state_in  = ffpea_pkg::ST_DROP;
                  end else begin
                     we         = 1'b1;
                     waddr      = pos_ff[ffpea_pkg::IDX_BITS-1:0];
                     wdata.base = cur_ff.base + cnt_ext;
                     wdata.size = cur_ff.size - cnt_ext;
                     state_in   = ffpea_pkg::ST_DONE;
                  end
               end
            end else if (join_lo && join_hi) begin
               we         = 1'b1;
               waddr      = pos_m1[ffpea_pkg::IDX_BITS-1:0];
               wdata.base = prev_ff.base;
               wdata.size = prev_ff.size + cnt_ext + cur_ff.size;
               rd_idx_in  = pos_ff + ffpea_pkg::TOTAL_BITS'(1);
               state_in   = ffpea_pkg::ST_DROP;
            end else if (join_lo) begin
               we         = 1'b1;
               waddr      = pos_m1[ffpea_pkg::IDX_BITS-1:0];
               wdata.base = prev_ff.base;
               wdata.size = prev_ff.size + cnt_ext;
               state_in   = ffpea_pkg::ST_DONE;
            end else if (join_hi) begin
               we         = 1'b1;
               waddr      = pos_ff[ffpea_pkg::IDX_BITS-1:0];
               wdata.base = start_ff;
               wdata.size = cur_ff.size + cnt_ext;
               state_in   = ffpea_pkg::ST_DONE;
            end else if (total_ff >= ffpea_pkg::TOTAL_MAX) begin
               status_in = ffpea_pkg::STATUS_FULL;
               state_in  = ffpea_pkg::ST_DONE;
            end else begin
               rd_idx_in = total_ff;
               state_in  = ffpea_pkg::ST_SHIFT;
            end
         end

         // close the gap: entry i+1 moves to i
         ffpea_pkg::ST_DROP: begin
            if (pend_ff) begin
               we    = 1'b1;
               waddr = chk_ff[ffpea_pkg::IDX_BITS-1:0];
               wdata = rdata;
            end
            if (rd_idx_ff < total_ff) begin
               raddr     = rd_idx_ff[ffpea_pkg::IDX_BITS-1:0];
               pend_in   = 1'b1;
               chk_in    = rd_m1;
               rd_idx_in = rd_idx_ff + ffpea_pkg::TOTAL_BITS'(1);
            end else begin
               pend_in  = 1'b0;
               total_in = total_ff - ffpea_pkg::TOTAL_BITS'(1);
               state_in = ffpea_pkg::ST_DONE;
            end
         end

         // open a gap at pos: entry i-1 moves to i, top down
         ffpea_pkg::ST_SHIFT: begin
            if (pend_ff) begin
               we    = 1'b1;
               waddr = chk_ff[ffpea_pkg::IDX_BITS-1:0];
               wdata = rdata;
            end
            if (rd_idx_ff > pos_ff) begin
               raddr     = rd_m1[ffpea_pkg::IDX_BITS-1:0];
               pend_in   = 1'b1;
               chk_in    = rd_idx_ff;
               rd_idx_in = rd_m1;
            end else begin
               pend_in  = 1'b0;
               state_in = ffpea_pkg::ST_INSERT;
            end
         end

         ffpea_pkg::ST_INSERT: begin
            we         = 1'b1;
            waddr      = pos_ff[ffpea_pkg::IDX_BITS-1:0];
            wdata.base = start_ff;
            wdata.size = cnt_ext;
            total_in   = total_ff + ffpea_pkg::TOTAL_BITS'(1);
            state_in   = ffpea_pkg::ST_DONE;
         end

         // hand the beat to the output register once it is free
         ffpea_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_start_in  = where_ff;
               rsp_total_in  = total_ff;
               state_in      = ffpea_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ffpea_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffpea_pkg::ST_IDLE;
         total_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      cnt_ff        <= cnt_in;
      start_ff      <= start_in;
      rd_idx_ff     <= rd_idx_in;
      chk_ff        <= chk_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      pos_ff        <= pos_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      where_ff      <= where_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_total_ff  <= rsp_total_in;
   end

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= ffpea_pkg::TOTAL_MAX)
      else $error("extent count above table depth");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffpea_pkg::ST_IDLE) |-> !we)
      else $error("table write while idle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff != ffpea_pkg::ST_IDLE))
      else $error("accepted request not processed");

   a_fail_no_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ffpea_pkg::STATUS_OK)) |-> (rsp_start_ff == '0))
      else $error("failed request reports a start page");

   a_total_step: assert property (@(posedge clock) disable iff (reset)
      (total_ff != $past(total_ff)) |->
         ($past(state_ff) == ffpea_pkg::ST_DROP || $past(state_ff) == ffpea_pkg::ST_INSERT))
      else $error("extent count changed outside remove or insert");
endmodule
`default_nettype wire

// ----- bench/first_fit_page_extent_allocator_test.sv -----
// Testbench for the first-fit page extent allocator: directed and random alloc/free traffic.
`default_nettype none
module first_fit_page_extent_allocator_test;
   typedef struct packed {
      logic [1:0]           status;
      ffpea_pkg::page_type  alloc_start;
      ffpea_pkg::total_type extents_in_use;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ffpea_req_if req_chan ();
   ffpea_rsp_if rsp_chan ();

   first_fit_page_extent_allocator u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #4 clock = ~clock;

   // Predictor copy of the free extent table.
   ffpea_pkg::page_type pred_base [ffpea_pkg::MAX_EXTENTS];
   ffpea_pkg::page_type pred_size [ffpea_pkg::MAX_EXTENTS];
   int        pred_total;
   answer_type answers_due [$];

   int  error_count = 0;
   bit  calm        = 1'b0;   // no idling in the last part of the run
   int  sent_beats  = 0;
   int  rsp_hold    = 0;      // remaining cycles of a response-side stall

   task automatic report(input string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   // Remove table entry pos, shifting the upper entries down.
   function automatic void pred_drop(input int pos);
      for (int i = pos; i + 1 < pred_total; i++) begin
         pred_base[i] = pred_base[i+1];
         pred_size[i] = pred_size[i+1];
      end
      pred_total--;
   endfunction

   // Work out the answer to one request and update the predicted table.
   function automatic answer_type predict_answer(input ffpea_pkg::op_type op,
                                                 input ffpea_pkg::count_type cnt,
                                                 input ffpea_pkg::page_type start);
      answer_type a;
      logic [63:0] cnt64;
      logic [63:0] start64;
      int pos;
      bit lo_join;
      bit hi_join;
      a = '0;
      cnt64 = 64'(cnt);
      start64 = 64'(start);
      if (cnt == 0) begin
         a.status = ffpea_pkg::STATUS_ZERO;
      end else if (op == ffpea_pkg::OP_ALLOC) begin
         a.status = ffpea_pkg::STATUS_NOSPACE;
         for (int i = 0; i < pred_total; i++) begin
            if (64'(pred_size[i]) >= cnt64) begin
               a.status = ffpea_pkg::STATUS_OK;
               a.alloc_start = pred_base[i];
               if (64'(pred_size[i]) == cnt64) begin
                  pred_drop(i);
               end else begin
                  pred_base[i] = pred_base[i] + ffpea_pkg::page_type'(cnt);
                  pred_size[i] = pred_size[i] - ffpea_pkg::page_type'(cnt);
               end
               break;
            end
         end
      end else begin
         a.status = ffpea_pkg::STATUS_OK;
         // Clip runs that would touch the top page index.
         if (start64 + cnt64 > 64'(ffpea_pkg::PG_MASK))
            cnt64 = 64'(ffpea_pkg::PG_MASK) - start64;
         if (cnt64 != 0) begin
            pos = 0;
            while (pos < pred_total && pred_base[pos] < start) pos++;
            lo_join = pos > 0 &&
                      (64'(pred_base[pos-1]) + 64'(pred_size[pos-1]) == start64);
            hi_join = pos < pred_total && (start64 + cnt64 == 64'(pred_base[pos]));
            if (lo_join && hi_join) begin
               pred_size[pos-1] = pred_size[pos-1] + ffpea_pkg::page_type'(cnt64)
                                + pred_size[pos];
               pred_drop(pos);
            end else if (lo_join) begin
               pred_size[pos-1] = pred_size[pos-1] + ffpea_pkg::page_type'(cnt64);
            end else if (hi_join) begin
               pred_base[pos] = start;
               pred_size[pos] = pred_size[pos] + ffpea_pkg::page_type'(cnt64);
            end else if (pred_total >= ffpea_pkg::MAX_EXTENTS) begin
               a.status = ffpea_pkg::STATUS_FULL;
            end else begin
               for (int i = pred_total; i > pos; i--) begin
                  pred_base[i] = pred_base[i-1];
                  pred_size[i] = pred_size[i-1];
               end
               pred_base[pos] = start;
               pred_size[pos] = ffpea_pkg::page_type'(cnt64);
               pred_total++;
            end
         end
      end
      a.extents_in_use = ffpea_pkg::total_type'(pred_total);
      return a;
   endfunction

   // Send one request beat; predicts its answer when it is accepted.
   // Valid stays high after the beat; the block is busy then, and the next
   // call or wait_drained replaces or drops it at the following falling edge.
   task automatic send_request(input ffpea_pkg::op_type op, input ffpea_pkg::count_type cnt,
                               input ffpea_pkg::page_type start);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.page_count <= cnt;
      req_chan.start_page <= start;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      answers_due.push_back(predict_answer(op, cnt, start));
      sent_beats++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (answers_due.size() != 0) @(negedge clock);
   endtask

   function automatic ffpea_pkg::page_type rand_page();
      return ffpea_pkg::page_type'({$urandom(), $urandom()});
   endfunction

   // Response side: random stall bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold != 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_hold = $urandom_range(0, 9);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Compare each response beat with the oldest expectation.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (answers_due.size() == 0) begin
            report("response with nothing expected");
         end else begin
            want = answers_due.pop_front();
            if (rsp_chan.status !== want.status)
               report($sformatf("status got %0d want %0d", rsp_chan.status, want.status));
            if (rsp_chan.alloc_start !== want.alloc_start)
               report($sformatf("alloc_start got %h want %h",
                                rsp_chan.alloc_start, want.alloc_start));
            if (rsp_chan.extents_in_use !== want.extents_in_use)
               report($sformatf("extents_in_use got %0d want %0d",
                                rsp_chan.extents_in_use, want.extents_in_use));
         end
      end
   end

   // Special cases: zero count, empty table, seeding, merges, top-of-space clipping.
   task automatic test_directed();
      send_request(ffpea_pkg::OP_ALLOC, 16'd5, '0);                 // empty table: no space
      send_request(ffpea_pkg::OP_FREE, 16'd0, 36'h123);             // zero count
      send_request(ffpea_pkg::OP_ALLOC, 16'd0, ffpea_pkg::PG_MASK); // zero count
      send_request(ffpea_pkg::OP_FREE, 16'd100, 36'd1000);          // free into empty table
      send_request(ffpea_pkg::OP_FREE, 16'd10, 36'd500);            // before first extent
      send_request(ffpea_pkg::OP_FREE, 16'd10, 36'd2000);           // above, no touch
      send_request(ffpea_pkg::OP_FREE, 16'd490, 36'd510);           // both sides merge
      send_request(ffpea_pkg::OP_FREE, 16'd50, 36'd1950);           // joins upper extent
      send_request(ffpea_pkg::OP_FREE, 16'd5, 36'd2010);            // joins lower extent
      send_request(ffpea_pkg::OP_ALLOC, 16'd600, '0);               // uses up first exactly
      send_request(ffpea_pkg::OP_ALLOC, 16'd65535, '0);             // too large
      send_request(ffpea_pkg::OP_ALLOC, 16'd65, '0);                // uses up extent exactly
      send_request(ffpea_pkg::OP_FREE, 16'd65535, ffpea_pkg::PG_MASK);  // clipped to nothing
      send_request(ffpea_pkg::OP_FREE, 16'd65535,
                   ffpea_pkg::PG_MASK - 36'd3);                     // clipped to three pages
      send_request(ffpea_pkg::OP_FREE, 16'd1, 36'd2000);            // one page of the run allocated above
      send_request(ffpea_pkg::OP_FREE, 16'd1, '0);                  // page zero
      send_request(ffpea_pkg::OP_ALLOC, 16'd1, 36'hFFFFFFFFF);
      wait_drained();
   endtask

   // Fill the table with isolated runs, then hit table full.
   task automatic test_table_full();
      for (int i = 0; i < ffpea_pkg::MAX_EXTENTS + 2; i++)
         send_request(ffpea_pkg::OP_FREE, ffpea_pkg::count_type'($urandom_range(1, 3)),
                      36'h800000000 + ffpea_pkg::page_type'(i * 8));
      send_request(ffpea_pkg::OP_FREE, 16'd4, 36'h800000004);  // merge still works when full
      send_request(ffpea_pkg::OP_FREE, 16'd1, 36'h900000000);  // no merge: full
      wait_drained();                                          // sender holds until drained
      for (int i = 0; i < 40; i++)
         send_request(ffpea_pkg::OP_ALLOC, ffpea_pkg::count_type'($urandom_range(1, 12)),
                      rand_page());
      wait_drained();
   endtask

   // Random traffic: mostly allocs and frees of previously allocated runs.
   task automatic test_random(input int beats);
      ffpea_pkg::page_type  held_start [$];
      ffpea_pkg::count_type held_cnt [$];
      int k;
      answer_type a;
      for (int n = 0; n < beats; n++) begin
         if (n == beats - 200) calm = 1'b1;
         k = $urandom_range(0, 99);
         if (k < 45) begin
            send_request(ffpea_pkg::OP_ALLOC,
                         ffpea_pkg::count_type'($urandom_range(1, (k < 3) ? 65535 : 300)),
                         rand_page());
            a = answers_due[$];
            if (a.status == ffpea_pkg::STATUS_OK) begin
               held_start.push_back(a.alloc_start);
               held_cnt.push_back(req_chan.page_count);
            end
         end else if (k < 85 && held_start.size() != 0) begin
            k = $urandom_range(0, held_start.size() - 1);
            send_request(ffpea_pkg::OP_FREE, held_cnt[k], held_start[k]);
            held_start.delete(k);
            held_cnt.delete(k);
         end else if (k < 90) begin
            send_request(ffpea_pkg::OP_FREE, 16'd0, rand_page());
         end else begin
            send_request(ffpea_pkg::OP_FREE, ffpea_pkg::count_type'($urandom()), rand_page());
         end
      end
      wait_drained();
   endtask

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.op         = ffpea_pkg::OP_ALLOC;
      req_chan.page_count = '0;
      req_chan.start_page = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_table_full();
      test_random(1200);
      repeat (2 * ffpea_pkg::MAX_EXTENTS + 20) @(posedge clock);
      if (error_count == 0 && answers_due.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #10000000;
      $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire
